// ----- src/bcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_pkg
// Types, constants and microcode program shared by the barometric conversion
// scheduler and compensator.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int W_TIME     = 32;
    localparam int W_ADC      = 24;
    localparam int W_COEF     = 16;
    localparam int W_WAIT     = 8;
    localparam int W_OSR      = 4;
    localparam int W_CFG_IDX  = 4;
    localparam int W_CFG_DATA = 16;
    localparam int W_KIND     = 2;
    localparam int W_CMD      = 8;
    localparam int W_TEMP     = 15;
    localparam int W_PRES     = 17;

    // datapath widths
    localparam int W_DT    = 25;
    localparam int W_MB    = 18;
    localparam int W_PROD  = W_DT + W_MB;
    localparam int W_OFF   = 36;
    localparam int W_SENS  = 34;
    localparam int W_ACC   = 59;
    localparam int W_TRAW  = 20;
    localparam int W_DIFF  = 40;
    localparam int W_PQ    = 25;
    localparam int SENS_LO = 17;

    localparam int SH_C5   = 8;
    localparam int SH_C2   = 16;
    localparam int SH_C1   = 15;
    localparam int SH_TEMP = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_P1   = 21;
    localparam int SH_P2   = 15;

    localparam int TEMP_BASE = 2000;
    localparam int TEMP_LOW  = -4000;
    localparam int TEMP_HIGH = 8500;
    localparam int PRES_LOW  = 1000;
    localparam int PRES_HIGH = 120000;

    localparam logic [W_CMD-1:0]  CMD_PRESSURE    = 8'h40;
    localparam logic [W_CMD-1:0]  CMD_TEMPERATURE = 8'h50;
    localparam logic [W_WAIT-1:0] WAIT_RESET      = 8'd10;
    localparam logic [W_OSR-1:0]  OSR_RESET       = 4'd8;

    typedef enum logic [W_KIND-1:0] {
        KIND_NONE        = 2'd0,
        KIND_PRESSURE    = 2'd1,
        KIND_TEMPERATURE = 2'd2
    } t_kind;

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_C1   = 4'd0,
        CFG_C2   = 4'd1,
        CFG_C3   = 4'd2,
        CFG_C4   = 4'd3,
        CFG_C5   = 4'd4,
        CFG_C6   = 4'd5,
        CFG_WAIT = 4'd6,
        CFG_OSR  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [W_COEF-1:0] c1;
        logic [W_COEF-1:0] c2;
        logic [W_COEF-1:0] c3;
        logic [W_COEF-1:0] c4;
        logic [W_COEF-1:0] c5;
        logic [W_COEF-1:0] c6;
        logic [W_WAIT-1:0] wait_ms;
        logic [W_OSR-1:0]  osr;
    } t_cfg;

    // microcode fields
    typedef enum logic {
        A_DT = 1'b0,
        A_D1 = 1'b1
    } t_a_sel;

    typedef enum logic [2:0] {
        B_C6  = 3'd0,
        B_C4  = 3'd1,
        B_C3  = 3'd2,
        B_SLO = 3'd3,
        B_SHI = 3'd4
    } t_b_sel;

    typedef enum logic [2:0] {
        WR_NONE    = 3'd0,
        WR_DT      = 3'd1,
        WR_TEMP    = 3'd2,
        WR_OFF     = 3'd3,
        WR_SENS    = 3'd4,
        WR_ACC_LD  = 3'd5,
        WR_ACC_ADD = 3'd6,
        WR_RESULT  = 3'd7
    } t_wr;

    typedef enum logic {
        SEQ_NEXT = 1'b0,
        SEQ_END  = 1'b1
    } t_seq;

    typedef struct packed {
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_wr    wr;
        t_seq   seq;
    } t_ucode;

    localparam int UCODE_LEN = 9;
    localparam int W_STEP    = $clog2(UCODE_LEN);

    localparam t_ucode UCODE_IDLE = '{A_DT, B_C6, WR_NONE, SEQ_NEXT};

    function automatic t_ucode ucode_rom(input logic [W_STEP-1:0] step);
        t_ucode w;
        case (step)
            4'd0:    w = '{A_DT, B_C6,  WR_DT,      SEQ_NEXT};
            4'd1:    w = '{A_DT, B_C6,  WR_NONE,    SEQ_NEXT};
            4'd2:    w = '{A_DT, B_C4,  WR_TEMP,    SEQ_NEXT};
            4'd3:    w = '{A_DT, B_C3,  WR_OFF,     SEQ_NEXT};
            4'd4:    w = '{A_DT, B_C3,  WR_SENS,    SEQ_NEXT};
            4'd5:    w = '{A_D1, B_SLO, WR_NONE,    SEQ_NEXT};
            4'd6:    w = '{A_D1, B_SHI, WR_ACC_LD,  SEQ_NEXT};
            4'd7:    w = '{A_D1, B_SHI, WR_ACC_ADD, SEQ_NEXT};
            4'd8:    w = '{A_D1, B_SHI, WR_RESULT,  SEQ_END};
            default: w = '{A_DT, B_C6,  WR_NONE,    SEQ_END};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- src/bcs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs interfaces
// Poll, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcs_poll_if;
    import bcs_pkg::*;
    logic              valid;
    logic              ready;
    logic [W_TIME-1:0] now_ms;
    logic [W_ADC-1:0]  adc_reading;
    modport source (output valid, now_ms, adc_reading, input ready);
    modport sink   (input valid, now_ms, adc_reading, output ready);
endinterface

interface bcs_result_if;
    import bcs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [W_KIND-1:0]        read_kind;
    logic [W_KIND-1:0]        start_kind;
    logic [W_CMD-1:0]         start_command;
    logic signed [W_TEMP-1:0] temperature_centi;
    logic [W_PRES-1:0]        pressure_centi_mbar;
    logic                     sample_error;
    modport source (output valid, read_kind, start_kind, start_command, temperature_centi,
                    pressure_centi_mbar, sample_error, input ready);
    modport sink   (input valid, read_kind, start_kind, start_command, temperature_centi,
                    pressure_centi_mbar, sample_error, output ready);
endinterface

interface bcs_cfg_if;
    import bcs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [W_CFG_IDX-1:0]  index;
    logic [W_CFG_DATA-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/bcs_sched.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_sched
// Conversion scheduler: pending flags, start times and raw value caches.
// ----------------------------------------------------------------------------
module bcs_sched (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_accept,
    input  wire [bcs_pkg::W_TIME-1:0]   i_now,
    input  wire [bcs_pkg::W_ADC-1:0]    i_adc,
    input  bcs_pkg::t_cfg               i_cfg,
    output bcs_pkg::t_kind              o_read_kind,
    output bcs_pkg::t_kind              o_start_kind,
    output logic [bcs_pkg::W_CMD-1:0]   o_cmd,
    output logic [bcs_pkg::W_ADC-1:0]   o_d1,
    output logic [bcs_pkg::W_ADC-1:0]   o_d2,
    output logic                        o_error
);
    import bcs_pkg::*;

    logic              r_p_pend, n_p_pend;
    logic              r_t_pend, n_t_pend;
    logic [W_TIME-1:0] r_p_time, n_p_time;
    logic [W_TIME-1:0] r_t_time, n_t_time;
    logic [W_ADC-1:0]  r_d1, n_d1;
    logic [W_ADC-1:0]  r_d2, n_d2;
    t_kind             r_read_kind, n_read_kind;
    t_kind             r_start_kind, n_start_kind;
    logic [W_CMD-1:0]  r_cmd, n_cmd;

    logic [W_TIME-1:0] p_elapsed;
    logic [W_TIME-1:0] t_elapsed;
    logic [W_TIME-1:0] wait_ext;

    assign p_elapsed = i_now - r_p_time;
    assign t_elapsed = i_now - r_t_time;
    assign wait_ext  = W_TIME'(i_cfg.wait_ms);

    always_comb begin
        n_p_pend     = r_p_pend;
        n_t_pend     = r_t_pend;
        n_p_time     = r_p_time;
        n_t_time     = r_t_time;
        n_d1         = r_d1;
        n_d2         = r_d2;
        n_read_kind  = KIND_NONE;
        n_start_kind = KIND_NONE;
        n_cmd        = '0;
        // pressure first
        if (r_p_pend && (p_elapsed >= wait_ext)) begin
            n_p_pend    = 1'b0;
            n_d1        = i_adc;
            n_read_kind = KIND_PRESSURE;
        end else if (!r_p_pend && !r_t_pend) begin
            n_p_pend     = 1'b1;
            n_p_time     = i_now;
            n_start_kind = KIND_PRESSURE;
            n_cmd        = CMD_PRESSURE + W_CMD'(i_cfg.osr);
        end
        // then temperature, against the updated pressure flag
        if (r_t_pend && (t_elapsed >= wait_ext)) begin
            n_t_pend    = 1'b0;
            n_d2        = i_adc;
            n_read_kind = KIND_TEMPERATURE;
        end else if (!r_t_pend && !n_p_pend) begin
            n_t_pend     = 1'b1;
            n_t_time     = i_now;
            n_start_kind = KIND_TEMPERATURE;
            n_cmd        = CMD_TEMPERATURE + W_CMD'(i_cfg.osr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_pend     <= 1'b0;
            r_t_pend     <= 1'b0;
            r_p_time     <= '0;
            r_t_time     <= '0;
            r_d1         <= '0;
            r_d2         <= '0;
            r_read_kind  <= KIND_NONE;
            r_start_kind <= KIND_NONE;
            r_cmd        <= '0;
        end else if (i_accept) begin
            r_p_pend     <= n_p_pend;
            r_t_pend     <= n_t_pend;
            r_p_time     <= n_p_time;
            r_t_time     <= n_t_time;
            r_d1         <= n_d1;
            r_d2         <= n_d2;
            r_read_kind  <= n_read_kind;
            r_start_kind <= n_start_kind;
            r_cmd        <= n_cmd;
        end
    end

    assign o_read_kind  = r_read_kind;
    assign o_start_kind = r_start_kind;
    assign o_cmd        = r_cmd;
    assign o_d1         = r_d1;
    assign o_d2         = r_d2;
    assign o_error      = (r_d1 == '0) || (r_d2 == '0);

endmodule
`default_nettype wire

// ----- src/bcs_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_seq
// Microcode sequencer: step counter over the compensation program.
// ----------------------------------------------------------------------------
module bcs_seq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire            i_out_free,
    output logic           o_busy,
    output bcs_pkg::t_ucode o_ctrl
);
    import bcs_pkg::*;

    logic              r_busy, n_busy;
    logic [W_STEP-1:0] r_step, n_step;
    t_ucode            word;
    logic              stall;

    assign word  = ucode_rom(r_step);
    assign stall = (word.seq == SEQ_END) && !i_out_free;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = '0;
            end
        end else if (word.seq == SEQ_END) begin
            if (i_out_free) begin
                n_busy = 1'b0;
                n_step = '0;
            end
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_comb begin
        o_ctrl = word;
        if (!r_busy) begin
            o_ctrl = UCODE_IDLE;
        end else if (stall) begin
            o_ctrl.wr = WR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

// ----- src/bcs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_datapath
// First-order compensation datapath around one shared 25x18 multiplier.
// ----------------------------------------------------------------------------
module bcs_datapath (
    input  wire                                i_clk,
    input  bcs_pkg::t_ucode                    i_ctrl,
    input  bcs_pkg::t_cfg                      i_cfg,
    input  wire [bcs_pkg::W_ADC-1:0]           i_d1,
    input  wire [bcs_pkg::W_ADC-1:0]           i_d2,
    output logic signed [bcs_pkg::W_TEMP-1:0]  o_temp,
    output logic [bcs_pkg::W_PRES-1:0]         o_pres
);
    import bcs_pkg::*;

    logic signed [W_DT-1:0]   r_dt;
    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_TEMP-1:0] r_temp;
    logic signed [W_OFF-1:0]  r_off;
    logic signed [W_SENS-1:0] r_sens;
    logic signed [W_ACC-1:0]  r_acc;

    logic signed [W_DT-1:0]   n_dt;
    logic signed [W_DT-1:0]   mul_a;
    logic signed [W_MB-1:0]   mul_b;
    logic signed [W_PROD-1:0] n_prod;
    logic signed [W_TRAW-1:0] t_raw;
    logic signed [W_TEMP-1:0] n_temp;
    logic signed [W_OFF-1:0]  n_off;
    logic signed [W_SENS-1:0] n_sens;
    logic signed [W_DIFF-1:0] p_diff;
    logic signed [W_PQ-1:0]   p_q;

    assign n_dt = signed'({1'b0, i_d2}) - signed'({1'b0, i_cfg.c5, SH_C5'(0)});

    always_comb begin
        case (i_ctrl.a_sel)
            A_DT:    mul_a = r_dt;
            A_D1:    mul_a = signed'({1'b0, i_d1});
            default: mul_a = r_dt;
        endcase
    end

    always_comb begin
        case (i_ctrl.b_sel)
            B_C6:    mul_b = signed'({2'b0, i_cfg.c6});
            B_C4:    mul_b = signed'({2'b0, i_cfg.c4});
            B_C3:    mul_b = signed'({2'b0, i_cfg.c3});
            B_SLO:   mul_b = signed'({1'b0, r_sens[SENS_LO-1:0]});
            B_SHI:   mul_b = signed'({r_sens[W_SENS-1], r_sens[W_SENS-1:SENS_LO]});
            default: mul_b = '0;
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // temperature, saturated
    assign t_raw = W_TRAW'(r_prod >>> SH_TEMP) + W_TRAW'(TEMP_BASE);
    always_comb begin
        if (t_raw < TEMP_LOW) begin
            n_temp = W_TEMP'(TEMP_LOW);
        end else if (t_raw > TEMP_HIGH) begin
            n_temp = W_TEMP'(TEMP_HIGH);
        end else begin
            n_temp = W_TEMP'(t_raw);
        end
    end

    assign n_off  = signed'(W_OFF'({i_cfg.c2, SH_C2'(0)})) + W_OFF'(r_prod >>> SH_OFF);
    assign n_sens = signed'(W_SENS'({i_cfg.c1, SH_C1'(0)})) + W_SENS'(r_prod >>> SH_SENS);

    // pressure, saturated
    assign p_diff = W_DIFF'(r_acc >>> SH_P1) - W_DIFF'(r_off);
    assign p_q    = W_PQ'(p_diff >>> SH_P2);
    always_comb begin
        if (p_q < PRES_LOW) begin
            o_pres = W_PRES'(PRES_LOW);
        end else if (p_q > PRES_HIGH) begin
            o_pres = W_PRES'(PRES_HIGH);
        end else begin
            o_pres = W_PRES'(p_q);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        case (i_ctrl.wr)
            WR_DT:      r_dt   <= n_dt;
            WR_TEMP:    r_temp <= n_temp;
            WR_OFF:     r_off  <= n_off;
            WR_SENS:    r_sens <= n_sens;
            WR_ACC_LD:  r_acc  <= W_ACC'(r_prod);
            WR_ACC_ADD: r_acc  <= r_acc + (W_ACC'(r_prod) <<< SENS_LO);
            default: begin
            end
        endcase
    end

    assign o_temp = r_temp;

endmodule
`default_nettype wire

// ----- src/baro_conversion_scheduler_compensator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_conversion_scheduler_compensator
// Barometric sensor conversion scheduler with first-order compensation.
// ----------------------------------------------------------------------------
// Each poll beat, taken only while idle, updates the conversion schedule and
// the raw caches; a nine-step microcode program then runs the compensation
// through a single shared 25x18 multiplier and writes its result beat into
// the output register, and no new poll is taken until the program ends. The
// output register frees the input side while a result waits; the last
// program step holds only while an earlier result is still not taken. The
// user must write coefficients and timing registers through the
// configuration port while no poll is in flight; the block itself does not
// enforce this. Writes to indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module baro_conversion_scheduler_compensator (
    input  wire           i_clk,
    input  wire           i_rst_n,
    bcs_poll_if.sink      i_poll,
    bcs_result_if.source  o_result,
    bcs_cfg_if.sink       i_cfg
);
    import bcs_pkg::*;

    t_cfg                     r_cfg;
    logic                     busy;
    logic                     accept;
    logic                     out_free;
    t_ucode                   ctrl;
    t_kind                    read_kind;
    t_kind                    start_kind;
    logic [W_CMD-1:0]         cmd;
    logic [W_ADC-1:0]         d1;
    logic [W_ADC-1:0]         d2;
    logic                     sample_err;
    logic signed [W_TEMP-1:0] temp;
    logic [W_PRES-1:0]        pres;

    logic                     r_out_valid;
    t_kind                    r_out_read_kind;
    t_kind                    r_out_start_kind;
    logic [W_CMD-1:0]         r_out_cmd;
    logic signed [W_TEMP-1:0] r_out_temp;
    logic [W_PRES-1:0]        r_out_pres;
    logic                     r_out_err;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c1      <= '0;
            r_cfg.c2      <= '0;
            r_cfg.c3      <= '0;
            r_cfg.c4      <= '0;
            r_cfg.c5      <= '0;
            r_cfg.c6      <= '0;
            r_cfg.wait_ms <= WAIT_RESET;
            r_cfg.osr     <= OSR_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_C1:   r_cfg.c1      <= i_cfg.data;
                CFG_C2:   r_cfg.c2      <= i_cfg.data;
                CFG_C3:   r_cfg.c3      <= i_cfg.data;
                CFG_C4:   r_cfg.c4      <= i_cfg.data;
                CFG_C5:   r_cfg.c5      <= i_cfg.data;
                CFG_C6:   r_cfg.c6      <= i_cfg.data;
                CFG_WAIT: r_cfg.wait_ms <= i_cfg.data[W_WAIT-1:0];
                CFG_OSR:  r_cfg.osr     <= i_cfg.data[W_OSR-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_poll.ready = !busy;
    assign accept       = i_poll.valid && !busy;
    assign out_free     = !r_out_valid || o_result.ready;

    bcs_sched u_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_now        (i_poll.now_ms),
        .i_adc        (i_poll.adc_reading),
        .i_cfg        (r_cfg),
        .o_read_kind  (read_kind),
        .o_start_kind (start_kind),
        .o_cmd        (cmd),
        .o_d1         (d1),
        .o_d2         (d2),
        .o_error      (sample_err)
    );

    bcs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    bcs_datapath u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_cfg  (r_cfg),
        .i_d1   (d1),
        .i_d2   (d2),
        .o_temp (temp),
        .o_pres (pres)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.wr == WR_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.wr == WR_RESULT) begin
            r_out_read_kind  <= read_kind;
            r_out_start_kind <= start_kind;
            r_out_cmd        <= cmd;
            r_out_temp       <= temp;
            r_out_pres       <= pres;
            r_out_err        <= sample_err;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.read_kind           = r_out_read_kind;
    assign o_result.start_kind          = r_out_start_kind;
    assign o_result.start_command       = r_out_cmd;
    assign o_result.temperature_centi   = r_out_temp;
    assign o_result.pressure_centi_mbar = r_out_pres;
    assign o_result.sample_error        = r_out_err;

endmodule
`default_nettype wire
